// ===== rtl/core/dcpl_pkg.sv =====
`timescale 1ns / 1ps

package dcpl_pkg;

   // full scale of a signed 32-bit sample
   localparam logic signed [31:0] FULL_SCALE = 32'sh7FFF_FFFF;

   // exact result is carried scaled by 2^48
   localparam int FRAC_W = 48;
   localparam int ACC_W  = 100;

   // saturation bounds, scaled by 2^48
   localparam logic signed [ACC_W-1:0] ACC_TOP = {20'h00000, 32'h7FFF_FFFF, 48'h0};
   localparam logic signed [ACC_W-1:0] ACC_BOT = {20'hFFFFF, 32'h8000_0000, 48'h0};

   // saturating counter ceiling
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // configuration register indexes
   localparam logic [7:0] CSR_SHIFT_FRACTION  = 8'd0;
   localparam logic [7:0] CSR_LIMITER_ENABLE  = 8'd1;
   localparam logic [7:0] CSR_LIMIT_THRESHOLD = 8'd2;
   localparam logic [7:0] CSR_LIMIT_SLOPE     = 8'd3;

   // operands after branch selection
   typedef struct packed {
      logic               limited;
      logic               neg;
      logic [34:0]        dmag;
      logic [63:0]        smag;
      logic signed [34:0] c;
      logic signed [31:0] f;
      logic signed [31:0] s;
   } prep_type;

   // partial products of |d| * |slope| and the plain-path offset product
   typedef struct packed {
      logic               limited;
      logic               neg;
      logic [49:0]        pp_ll;
      logic [49:0]        pp_lh;
      logic [48:0]        pp_hl;
      logic [48:0]        pp_hh;
      logic signed [62:0] fscale;
      logic signed [34:0] c;
      logic signed [31:0] f;
      logic signed [31:0] s;
   } prod_type;

   // product magnitude summed
   typedef struct packed {
      logic               limited;
      logic               neg;
      logic [98:0]        mag;
      logic signed [62:0] fscale;
      logic signed [34:0] c;
      logic signed [31:0] f;
      logic signed [31:0] s;
   } sum_type;

   // exact value scaled by 2^48
   typedef struct packed {
      logic                   limited;
      logic signed [ACC_W-1:0] acc;
   } acc_type;

endpackage

// ===== rtl/core/dc_shift_with_peak_limiter.sv =====
`timescale 1ns / 1ps

// Throughput: one beat per cycle while rsp_tready does not stall the output, set by the
//   multiply pipeline (split 35x64 partial products, magnitude sum, offset add, saturate).
// Reset (synchronous, active high): clears all stage valids, both running
//   counters and all configuration registers to zero.
module dc_shift_with_peak_limiter (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: [31:0] in_sample
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,
   // rsp_tdata: [31:0] out_sample, [63:32] clip_total, [95:64] limit_total
   // rsp_tuser: [0] was_clipped, [1] was_limited
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   // configuration
   logic signed [31:0] shift_ff;
   logic               lim_en_ff;
   logic signed [33:0] thresh_ff;
   logic [63:0]        slope_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '0;
         lim_en_ff <= 1'b0;
         thresh_ff <= '0;
         slope_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dcpl_pkg::CSR_SHIFT_FRACTION:  shift_ff  <= csr_wdata[31:0];
            dcpl_pkg::CSR_LIMITER_ENABLE:  lim_en_ff <= csr_wdata[0];
            dcpl_pkg::CSR_LIMIT_THRESHOLD: thresh_ff <= csr_wdata[33:0];
            dcpl_pkg::CSR_LIMIT_SLOPE:     slope_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline valids and per-stage ready
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vout_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

   assign rdy_out    = !vout_ff || rsp_tready;
   assign rdy5       = !v5_ff || rdy_out;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff   <= req_tvalid;
         if (rdy2)    v2_ff   <= v1_ff;
         if (rdy3)    v3_ff   <= v2_ff;
         if (rdy4)    v4_ff   <= v3_ff;
         if (rdy5)    v5_ff   <= v4_ff;
         if (rdy_out) vout_ff <= v5_ff;
      end
   end

   // stage 1: input register
   logic signed [31:0] samp_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) samp_ff <= req_tdata[31:0];
   end

   // stage 2: branch selection and operand magnitudes
   dcpl_pkg::prep_type st2_in, st2_ff;
   logic signed [33:0] s34;
   logic signed [34:0] s35, t35, d35;
   logic               up, down;

   always_comb begin
      s34 = {{2{samp_ff[31]}}, samp_ff};
      s35 = {{3{samp_ff[31]}}, samp_ff};
      t35 = {thresh_ff[33], thresh_ff};
      up   = lim_en_ff && !shift_ff[31] && (shift_ff != 32'sd0) && (s34 > thresh_ff);
      down = lim_en_ff && !up && shift_ff[31] && (s35 < -t35);
      d35  = up ? (s35 - t35) : (s35 + t35);
      st2_in.limited = up || down;
      st2_in.neg     = d35[34] ^ slope_ff[63];
      st2_in.dmag    = d35[34] ? 35'(-d35) : 35'(d35);
      st2_in.smag    = slope_ff[63] ? (64'd0 - slope_ff) : slope_ff;
      st2_in.c       = up ? t35 : -t35;
      st2_in.f       = shift_ff;
      st2_in.s       = samp_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) st2_ff <= st2_in;
   end

   // stage 3: partial products, 18/17 x 32 bits each
   dcpl_pkg::prod_type st3_in, st3_ff;

   always_comb begin
      st3_in.limited = st2_ff.limited;
      st3_in.neg     = st2_ff.neg;
      st3_in.pp_ll   = 50'(st2_ff.dmag[17:0])  * 50'(st2_ff.smag[31:0]);
      st3_in.pp_lh   = 50'(st2_ff.dmag[17:0])  * 50'(st2_ff.smag[63:32]);
      st3_in.pp_hl   = 49'(st2_ff.dmag[34:18]) * 49'(st2_ff.smag[31:0]);
      st3_in.pp_hh   = 49'(st2_ff.dmag[34:18]) * 49'(st2_ff.smag[63:32]);
      st3_in.fscale  = 63'(st2_ff.f) * 63'(dcpl_pkg::FULL_SCALE);
      st3_in.c       = st2_ff.c;
      st3_in.f       = st2_ff.f;
      st3_in.s       = st2_ff.s;
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) st3_ff <= st3_in;
   end

   // stage 4: sum of partial products
   dcpl_pkg::sum_type st4_in, st4_ff;

   always_comb begin
      st4_in.limited = st3_ff.limited;
      st4_in.neg     = st3_ff.neg;
      st4_in.mag     = {49'd0, st3_ff.pp_ll}
                     + {17'd0, st3_ff.pp_lh, 32'd0}
                     + {32'd0, st3_ff.pp_hl, 18'd0}
                     + {st3_ff.pp_hh, 50'd0};
      st4_in.fscale  = st3_ff.fscale;
      st4_in.c       = st3_ff.c;
      st4_in.f       = st3_ff.f;
      st4_in.s       = st3_ff.s;
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) st4_ff <= st4_in;
   end

   // stage 5: exact value scaled by 2^48
   dcpl_pkg::acc_type st5_in, st5_ff;
   logic signed [dcpl_pkg::ACC_W-1:0] prod_s, c_s, f_s, s_s, fs_s;

   always_comb begin
      prod_s = {1'b0, st4_ff.mag};
      if (st4_ff.neg) prod_s = -prod_s;
      c_s  = {{17{st4_ff.c[34]}}, st4_ff.c, 48'd0};
      f_s  = {{50{st4_ff.f[31]}}, st4_ff.f, 18'd0};
      s_s  = {{20{st4_ff.s[31]}}, st4_ff.s, 48'd0};
      fs_s = {{19{st4_ff.fscale[62]}}, st4_ff.fscale, 18'd0};
      st5_in.limited = st4_ff.limited;
      st5_in.acc     = st4_ff.limited ? (prod_s + c_s + f_s) : (s_s + fs_s);
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) st5_ff <= st5_in;
   end

   // stage 6: truncate toward zero, saturate, count
   logic        clip_hi, clip_lo, clipped, rnd;
   logic [31:0] res;
   logic        load_out;
   logic [31:0] clip_cnt_ff, clip_cnt_in, lim_cnt_ff, lim_cnt_in;
   logic [31:0] out_samp_ff;
   logic        out_clip_ff, out_lim_ff;

   always_comb begin
      clip_hi = st5_ff.acc > dcpl_pkg::ACC_TOP;
      clip_lo = st5_ff.acc < dcpl_pkg::ACC_BOT;
      clipped = clip_hi || clip_lo;
      rnd     = st5_ff.acc[dcpl_pkg::ACC_W-1] && (st5_ff.acc[dcpl_pkg::FRAC_W-1:0] != '0);
      if (clip_hi)      res = 32'h7FFF_FFFF;
      else if (clip_lo) res = 32'h8000_0000;
      else              res = st5_ff.acc[79:48] + {31'd0, rnd};
      load_out    = rdy_out && v5_ff;
      clip_cnt_in = clip_cnt_ff;
      lim_cnt_in  = lim_cnt_ff;
      if (load_out && clipped && clip_cnt_ff != dcpl_pkg::CNT_MAX)
         clip_cnt_in = clip_cnt_ff + 32'd1;
      if (load_out && st5_ff.limited && lim_cnt_ff != dcpl_pkg::CNT_MAX)
         lim_cnt_in = lim_cnt_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_cnt_ff <= '0;
         lim_cnt_ff  <= '0;
      end else begin
         clip_cnt_ff <= clip_cnt_in;
         lim_cnt_ff  <= lim_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_samp_ff <= res;
         out_clip_ff <= clipped;
         out_lim_ff  <= st5_ff.limited;
      end
   end

   assign rsp_tvalid = vout_ff;
   assign rsp_tdata  = {lim_cnt_ff, clip_cnt_ff, out_samp_ff};
   assign rsp_tuser  = {out_lim_ff, out_clip_ff};

`ifndef SYNTHESIS
   // the clip counter only ever moves up by one, and only on a result load
   a_clip_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (clip_cnt_ff != $past(clip_cnt_ff)) |->
         ($past(load_out) && clip_cnt_ff == $past(clip_cnt_ff) + 32'd1))
      else $error("clip counter moved without a clipped result");

   // a clipped result sits on a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000))
      else $error("clipped result not saturated");

   // limiter results only come with the limiter enabled
   a_lim_en: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> lim_en_ff)
      else $error("limited result with limiter off");

   // input stalls only behind a held item
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && vout_ff))
      else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

// ===== tb/dc_shift_with_peak_limiter_test.sv =====
`timescale 1ns / 1ps

module dc_shift_with_peak_limiter_test;

   // first register index that maps to nothing
   localparam logic [7:0] CSR_UNMAPPED_LO = 8'd4;

   // saturation bounds of the exact value, scaled by 2^48
   localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF <<< 48;
   localparam logic signed [127:0] SAT_LO = -(128'sh8000_0000 <<< 48);

   // reload value of the forced receiver hold-off counter
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [31:0] sample;
      logic        clipped;
      logic        limited;
      logic [31:0] clip_total;
      logic [31:0] limit_total;
   } shaped_beat_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // [31:0] in_sample
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // [31:0] out_sample, [63:32] clip_total, [95:64] limit_total
   logic [1:0]   rsp_tuser;        // [0] was_clipped, [1] was_limited
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   dc_shift_with_peak_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of the registers and counters
   logic signed [31:0] shift_q;
   logic               limiter_on;
   logic signed [33:0] threshold_q;
   logic signed [63:0] slope_q;
   logic [31:0]        clip_count;
   logic [31:0]        limit_count;

   shaped_beat_type shaped_q[$];
   logic [31:0]  pending_samples[$];
   int           queued_count = 0;
   int           accepted_count = 0;
   int           error_count = 0;
   logic         req_taken = 1'b0;
   logic         csr_taken = 1'b0;

   // stimulus side
   logic signed [33:0] stim_threshold = '0;
   int burst_left = 0;
   int gap_left = 0;

   // receiver side
   int          long_stalls_wanted = 0;
   int          long_stalls_done = 0;
   int          hold_left = 0;
   int          pattern_left = 0;
   rx_mode_type pattern = RX_OPEN;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      // keep the log short when everything goes wrong
      if (error_count <= 60)
         $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
   endtask

   // exact shift or limiter value, truncated toward zero and saturated
   function automatic shaped_beat_type shape_sample(input logic [31:0] raw);
      logic signed [127:0] s, t, f, m, acc, trunc;
      logic                up, down;
      shaped_beat_type     beat;
      s = 128'($signed(raw));
      t = 128'(threshold_q);
      f = 128'(shift_q);
      m = 128'(slope_q);
      up = limiter_on && f > 0 && s > t;
      down = limiter_on && !up && f < 0 && s < -t;
      beat.limited = up || down;
      // limiter adds the raw fraction, the plain path scales it to full scale
      if (up)
         acc = (s - t) * m + (t <<< 48) + (f <<< 18);
      else if (down)
         acc = (s + t) * m - (t <<< 48) + (f <<< 18);
      else
         acc = (s <<< 48) + ((f * 128'(dcpl_pkg::FULL_SCALE)) <<< 18);
      beat.clipped = (acc > SAT_HI) || (acc < SAT_LO);
      if (acc > SAT_HI)
         beat.sample = 32'h7FFF_FFFF;
      else if (acc < SAT_LO)
         beat.sample = 32'h8000_0000;
      else begin
         trunc = (acc < 0) ? -((-acc) >>> 48) : (acc >>> 48);
         beat.sample = trunc[31:0];
      end
      if (beat.limited && limit_count != dcpl_pkg::CNT_MAX)
         limit_count++;
      if (beat.clipped && clip_count != dcpl_pkg::CNT_MAX)
         clip_count++;
      beat.clip_total = clip_count;
      beat.limit_total = limit_count;
      return beat;
   endfunction

   // all handshakes are sampled here, at the rising edge
   always @(posedge clock) begin : sample_side
      shaped_beat_type want;
      if (reset) begin
         shift_q = '0;
         limiter_on = 1'b0;
         threshold_q = '0;
         slope_q = '0;
         clip_count = '0;
         limit_count = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dcpl_pkg::CSR_SHIFT_FRACTION:  shift_q = csr_wdata[31:0];
               dcpl_pkg::CSR_LIMITER_ENABLE:  limiter_on = csr_wdata[0];
               dcpl_pkg::CSR_LIMIT_THRESHOLD: threshold_q = csr_wdata[33:0];
               dcpl_pkg::CSR_LIMIT_SLOPE:     slope_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            shaped_q.push_back(shape_sample(req_tdata));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (shaped_q.size() == 0) begin
               report_mismatch("result beat with nothing expected",
                               64'(rsp_tdata[31:0]), '0);
            end else begin
               want = shaped_q.pop_front();
               if (rsp_tdata[31:0] !== want.sample)
                  report_mismatch("out_sample", 64'(rsp_tdata[31:0]), 64'(want.sample));
               if (rsp_tuser[0] !== want.clipped)
                  report_mismatch("was_clipped", 64'(rsp_tuser[0]), 64'(want.clipped));
               if (rsp_tuser[1] !== want.limited)
                  report_mismatch("was_limited", 64'(rsp_tuser[1]), 64'(want.limited));
               if (rsp_tdata[63:32] !== want.clip_total)
                  report_mismatch("clip_total", 64'(rsp_tdata[63:32]),
                                  64'(want.clip_total));
               if (rsp_tdata[95:64] !== want.limit_total)
                  report_mismatch("limit_total", 64'(rsp_tdata[95:64]),
                                  64'(want.limit_total));
            end
         end
      end
      req_taken <= !reset && req_tvalid && req_tready;
      csr_taken <= !reset && csr_valid && csr_ready;
   end

   // sample driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_tdata <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: shifting stall patterns, plus forced long hold-offs
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_stalls_done != long_stalls_wanted) begin
         long_stalls_done++;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern = rx_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(8, 80);
         end else begin
            pattern_left--;
         end
         case (pattern)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= (pattern_left % 3 != 0);
         endcase
      end
   end

   task automatic write_csr(input logic [7:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // all four registers, with junk above the width of each narrower register
   task automatic apply_setting(input logic [31:0] shift, input logic enable,
                                input logic [33:0] thr, input logic [63:0] slope);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      write_csr(dcpl_pkg::CSR_SHIFT_FRACTION, {noise[63:32], shift});
      write_csr(dcpl_pkg::CSR_LIMITER_ENABLE, {noise[63:1], enable});
      write_csr(dcpl_pkg::CSR_LIMIT_THRESHOLD, {noise[63:34], thr});
      write_csr(dcpl_pkg::CSR_LIMIT_SLOPE, slope);
      stim_threshold = thr;
   endtask

   task automatic random_setting();
      logic [31:0] shift;
      logic [33:0] thr;
      logic [63:0] slope;
      logic [63:0] noise;
      logic        enable;
      noise = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0:       shift = 32'h0;
         1:       shift = 32'h7FFF_FFFF;
         2:       shift = 32'h8000_0000;
         3, 4:    shift = $urandom_range(1, 32'h1000_0000);
         5, 6:    shift = -$urandom_range(1, 32'h1000_0000);
         default: shift = $urandom;
      endcase
      enable = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 6))
         0:       thr = 34'h0;
         1:       thr = 34'h1_FFFF_FFFF;
         2:       thr = 34'h2_0000_0000;
         3, 4:    thr = 34'($urandom_range(0, 32'h7FFF_FFFF));
         5:       thr = -34'($urandom_range(0, 32'h7FFF_FFFF));
         default: thr = noise[33:0];
      endcase
      case ($urandom_range(0, 7))
         0: slope = 64'h0;
         1: slope = 64'h0001_0000_0000_0000;   // unity gain
         2: slope = 64'h7FFF_FFFF_FFFF_FFFF;
         3: slope = 64'h8000_0000_0000_0000;
         4, 5: begin
            // moderate gain, either sign
            slope = {$urandom, $urandom} >> 15;
            if ($urandom_range(0, 1) == 1)
               slope = -slope;
         end
         default: slope = {$urandom, $urandom};
      endcase
      apply_setting(shift, enable, thr, slope);
      if ($urandom_range(0, 2) == 0)
         write_csr(8'($urandom_range(CSR_UNMAPPED_LO, 8'hFF)), {$urandom, $urandom});
   endtask

   // extremes, small values and values hugging either threshold
   function automatic logic [31:0] pick_sample();
      logic signed [63:0] anchor;
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 64) - 32;
         3, 4: begin
            anchor = 64'(stim_threshold);
            if ($urandom_range(0, 1) == 1)
               anchor = -anchor;
            anchor = anchor + $signed(64'($urandom_range(0, 6))) - 64'sd3;
            if (anchor >= -64'sd2147483648 && anchor <= 64'sd2147483647)
               return anchor[31:0];
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic offer(input logic [31:0] sample);
      pending_samples.push_back(sample);
      queued_count++;
   endtask

   // wait until every sample is in and every result is out
   task automatic drain();
      while (accepted_count != queued_count || shaped_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("[dc_shift_with_peak_limiter] ERROR");
      $finish;
   end

   initial begin : stimulus
      int ph, k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset: zero shift passes samples unchanged
      offer(32'h0); offer(32'h7FFF_FFFF); offer(32'h8000_0000);
      offer(32'hFFFF_FFFF); offer(32'h0000_0001);
      drain();

      // plain shift at both extremes of the fraction
      apply_setting(32'h7FFF_FFFF, 1'b0, 34'h0, 64'h0);
      offer(32'h8000_0000); offer(32'h0);
      drain();
      write_csr(dcpl_pkg::CSR_SHIFT_FRACTION, 64'h8000_0000);
      offer(32'h7FFF_FFFF); offer(32'hFFFF_FFFF);
      drain();

      // limiter up with a half-sample offset: full scale plus a half clips
      apply_setting(32'h2000_0000, 1'b1, 34'h0, 64'h0001_0000_0000_0000);
      offer(32'h7FFF_FFFF); offer(32'h5); offer(32'h0); offer(32'hFFFF_FFFD);
      drain();

      // limiter down: minus a half truncates toward zero, minimum clips
      apply_setting(32'hE000_0000, 1'b1, 34'h0, 64'h0001_0000_0000_0000);
      offer(32'h8000_0000); offer(32'hFFFF_FFFB); offer(32'h1);
      drain();

      // threshold and slope extremes
      apply_setting(32'h1, 1'b1, 34'h2_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      offer(32'h0); offer(32'h8000_0000);
      drain();
      write_csr(dcpl_pkg::CSR_LIMIT_SLOPE, 64'h8000_0000_0000_0000);
      offer(32'h0);
      drain();
      apply_setting(32'hFFFF_FFFF, 1'b1, 34'h1_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      offer(32'h8000_0000); offer(32'h7FFF_FFFF);
      drain();

      // random settings, each followed by a run of samples
      for (ph = 0; ph < 12; ph++) begin
         random_setting();
         for (k = 0; k < 142; k++)
            offer(pick_sample());
         if (ph == 4 || ph == 9)
            long_stalls_wanted++;
         drain();
      end

      // wait out the pipeline; catch any stray result beat
      repeat (16) @(negedge clock);
      if (shaped_q.size() != 0)
         report_mismatch("results never arrived", 64'(shaped_q.size()), '0);
      if (error_count == 0)
         $display("[dc_shift_with_peak_limiter] OK");
      else
         $display("[dc_shift_with_peak_limiter] ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/dcpl_pkg.sv
rtl/core/dc_shift_with_peak_limiter.sv
tb/dc_shift_with_peak_limiter_test.sv
